[rtl/wsm_pkg.sv]
// ----------------------------------------------------------------------------
// wsm_pkg
// Shared widths, codes, register layout and control types of the omni chassis
// wheel speed mixer.
// ----------------------------------------------------------------------------
package wsm_pkg;

   localparam int DIR_W       = 3;
   localparam int SPEED_W     = 16;
   localparam int TARGET_W    = 16;
   localparam int FILT_W      = 24;
   localparam int TURN_W      = 24;
   localparam int WHEEL_W     = 26;
   localparam int MAG_W       = 25;
   localparam int OUT_W       = 22;
   localparam int GAIN_W      = 16;
   localparam int OGAIN_W     = 24;
   localparam int OP_W        = 25;
   localparam int PROD_W      = 2 * OP_W;
   localparam int NUM_AXES    = 3;
   localparam int NUM_WHEELS  = 4;
   localparam int IDX_W       = $clog2(NUM_WHEELS);

   localparam int TARGET_SHIFT = 8;
   localparam int FILT_SHIFT   = 16;
   localparam int ARM_SHIFT    = 16;
   localparam int GAIN_SHIFT   = 14;
   localparam int OUT_SHIFT    = 20;
   localparam int NORM_SHIFT   = 20;
   localparam int DIV_STEPS    = NORM_SHIFT + 1;
   localparam int QUOT_W       = DIV_STEPS + 1;

   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = NUM_WHEELS * OUT_W;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [MAG_W-1:0] NORM_ONE = MAG_W'(1) << NORM_SHIFT;

   localparam logic [DIR_W-1:0] DIR_STOP       = 3'd0;
   localparam logic [DIR_W-1:0] DIR_FORWARD    = 3'd1;
   localparam logic [DIR_W-1:0] DIR_BACK       = 3'd2;
   localparam logic [DIR_W-1:0] DIR_LEFT       = 3'd3;
   localparam logic [DIR_W-1:0] DIR_RIGHT      = 3'd4;
   localparam logic [DIR_W-1:0] DIR_TURN_LEFT  = 3'd5;
   localparam logic [DIR_W-1:0] DIR_TURN_RIGHT = 3'd6;

   localparam logic [IDX_W-1:0] AXIS_X    = 2'd0;
   localparam logic [IDX_W-1:0] AXIS_Y    = 2'd1;
   localparam logic [IDX_W-1:0] AXIS_TURN = 2'd2;

   localparam logic [IDX_W-1:0] WHEEL_LF = 2'd0;
   localparam logic [IDX_W-1:0] WHEEL_LB = 2'd1;
   localparam logic [IDX_W-1:0] WHEEL_RB = 2'd2;
   localparam logic [IDX_W-1:0] WHEEL_RF = 2'd3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SMOOTHING_GAIN = 3'd0,
      CSR_ARM_LENGTH     = 3'd1,
      CSR_FRONT_GAIN     = 3'd2,
      CSR_BACK_GAIN      = 3'd3,
      CSR_OUTPUT_GAIN    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  smoothing_gain;
      logic [GAIN_W-1:0]  arm_length;
      logic [GAIN_W-1:0]  front_gain;
      logic [GAIN_W-1:0]  back_gain;
      logic [OGAIN_W-1:0] output_gain;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      smoothing_gain: 16'd9830,
      arm_length:     16'd13107,
      front_gain:     16'd17203,
      back_gain:      16'd16384,
      output_gain:    24'd1724631
   };

   typedef enum logic [2:0] {
      MUL_NONE = 3'd0,
      MUL_GT   = 3'd1,
      MUL_GF   = 3'd2,
      MUL_ARM  = 3'd3,
      MUL_GAIN = 3'd4,
      MUL_OUT  = 3'd5
   } mul_sel_type;

   typedef enum logic [2:0] {
      WR_NONE = 3'd0,
      WR_ACC  = 3'd1,
      WR_FILT = 3'd2,
      WR_TURN = 3'd3,
      WR_MIX  = 3'd4,
      WR_DIV  = 3'd5,
      WR_RES  = 3'd6
   } wr_sel_type;

   typedef struct packed {
      logic             load;
      mul_sel_type      mul_sel;
      wr_sel_type       wr_sel;
      logic [IDX_W-1:0] idx;
      logic             div_start;
      logic             rsp_load;
   } cmd_type;

   typedef struct packed {
      logic norm_needed;
      logic div_done;
   } sts_type;

endpackage

[rtl/wsm_div.sv]
// ----------------------------------------------------------------------------
// wsm_div
// Radix-2 restoring divider for wheel normalization: one quotient bit per
// cycle, floor of signed wheel * 2^20 over the largest magnitude.
// ----------------------------------------------------------------------------
module wsm_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               neg,
   input  logic [wsm_pkg::MAG_W-1:0]          mag,
   input  logic [wsm_pkg::MAG_W-1:0]          divisor,
   output logic                               done,
   output logic signed [wsm_pkg::QUOT_W-1:0]  quot
);

   localparam int CNT_W = $clog2(wsm_pkg::DIV_STEPS + 1);

   logic [wsm_pkg::MAG_W:0]         rem_ff, rem_in;
   logic [wsm_pkg::DIV_STEPS-1:0]   q_ff, q_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic                            neg_ff, neg_in;
   logic [wsm_pkg::MAG_W-1:0]       divisor_ff, divisor_in;
   logic [wsm_pkg::MAG_W:0]         trial;
   logic [wsm_pkg::MAG_W:0]         rem_step;
   logic                            ge;
   logic [wsm_pkg::QUOT_W-1:0]      q_ext;

   assign ge       = rem_ff >= {1'b0, divisor_ff};
   assign trial    = rem_ff - {1'b0, divisor_ff};
   assign rem_step = ge ? trial : rem_ff;

   always_comb begin
      rem_in     = rem_ff;
      q_in       = q_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      neg_in     = neg_ff;
      divisor_in = divisor_ff;
      if (start) begin
         rem_in     = {1'b0, mag};
         q_in       = '0;
         cnt_in     = CNT_W'(wsm_pkg::DIV_STEPS);
         busy_in    = 1'b1;
         neg_in     = neg;
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in = {rem_step[wsm_pkg::MAG_W-1:0], 1'b0};
         q_in   = {q_ff[wsm_pkg::DIV_STEPS-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      q_ff       <= q_in;
      cnt_ff     <= cnt_in;
      neg_ff     <= neg_in;
      divisor_ff <= divisor_in;
   end

   // negative with a remainder rounds down one more: -(q + 1) is ~q
   assign q_ext = wsm_pkg::QUOT_W'(q_ff);
   assign quot  = neg_ff ? ((rem_ff != '0) ? ~q_ext : -q_ext) : q_ext;
   assign done  = done_ff;

endmodule

[rtl/wsm_dp.sv]
// ----------------------------------------------------------------------------
// wsm_dp
// Datapath: direction latch and axis targets, smoothing filter state, one
// shared 25x25 multiplier, wheel mixing, normalization divider, gain stage
// and the result register.
// ----------------------------------------------------------------------------
module wsm_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  wsm_pkg::cmd_type                     cmd,
   input  wsm_pkg::cfg_type                     cfg,
   input  logic [wsm_pkg::REQ_DATA_W-1:0]       req_tdata,
   output wsm_pkg::sts_type                     sts,
   output logic [wsm_pkg::RSP_DATA_W-1:0]       rsp_tdata
);

   localparam int OUT_FULL_W = wsm_pkg::PROD_W - wsm_pkg::OUT_SHIFT;
   localparam logic signed [wsm_pkg::OUT_W-1:0] OUT_MAX =
      {1'b0, {(wsm_pkg::OUT_W-1){1'b1}}};
   localparam logic signed [wsm_pkg::OUT_W-1:0] OUT_MIN =
      {1'b1, {(wsm_pkg::OUT_W-1){1'b0}}};
   localparam logic signed [wsm_pkg::SPEED_W-1:0] SPEED_MIN =
      {1'b1, {(wsm_pkg::SPEED_W-1){1'b0}}};
   localparam logic signed [wsm_pkg::SPEED_W-1:0] SPEED_MAX =
      {1'b0, {(wsm_pkg::SPEED_W-1){1'b1}}};

   logic [wsm_pkg::DIR_W-1:0]              dir;
   logic signed [wsm_pkg::SPEED_W-1:0]     spd, spd_neg;
   logic [wsm_pkg::DIR_W-1:0]              latched_dir_ff, latched_dir_in;
   logic signed [wsm_pkg::TARGET_W-1:0]    target_ff [wsm_pkg::NUM_AXES];
   logic signed [wsm_pkg::TARGET_W-1:0]    target_in [wsm_pkg::NUM_AXES];
   logic signed [wsm_pkg::FILT_W-1:0]      filt_ff [wsm_pkg::NUM_AXES];
   logic signed [wsm_pkg::FILT_W-1:0]      filt_in [wsm_pkg::NUM_AXES];
   logic signed [wsm_pkg::TURN_W-1:0]      turn_ff, turn_in;
   logic signed [wsm_pkg::WHEEL_W-1:0]     wheel_ff [wsm_pkg::NUM_WHEELS];
   logic signed [wsm_pkg::WHEEL_W-1:0]     wheel_in [wsm_pkg::NUM_WHEELS];
   logic [wsm_pkg::MAG_W-1:0]              mx_ff, mx_in;
   logic signed [wsm_pkg::PROD_W-1:0]      prod_ff, prod_in, acc_ff, acc_in, filt_sum;
   logic signed [wsm_pkg::OP_W-1:0]        mul_a, mul_b;
   logic [wsm_pkg::GAIN_W:0]               gain_comp;
   logic [wsm_pkg::GAIN_W-1:0]             wheel_gain;
   logic signed [wsm_pkg::TARGET_W-1:0]    target_sel;
   logic signed [wsm_pkg::FILT_W-1:0]      filt_sel;
   logic signed [wsm_pkg::WHEEL_W-1:0]     wheel_sel, wheel_sel_mag;
   logic signed [wsm_pkg::WHEEL_W-1:0]     x_term, y_term, mix_sum, mix_mag_full;
   logic [wsm_pkg::MAG_W-1:0]              mix_mag, div_mag;
   logic                                   x_neg, y_neg;
   logic signed [OUT_FULL_W-1:0]           out_full;
   logic signed [wsm_pkg::OUT_W-1:0]       out_sat;
   logic signed [wsm_pkg::OUT_W-1:0]       res_ff [wsm_pkg::NUM_WHEELS];
   logic signed [wsm_pkg::OUT_W-1:0]       res_in [wsm_pkg::NUM_WHEELS];
   logic [wsm_pkg::RSP_DATA_W-1:0]         rsp_tdata_ff, rsp_tdata_in;
   logic signed [wsm_pkg::QUOT_W-1:0]      div_quot;
   logic                                   div_done;

   assign dir     = req_tdata[wsm_pkg::DIR_W-1:0];
   assign spd     = req_tdata[wsm_pkg::DIR_W +: wsm_pkg::SPEED_W];
   assign spd_neg = (spd == SPEED_MIN) ? SPEED_MAX : -spd;

   always_comb begin
      latched_dir_in = latched_dir_ff;
      target_in      = target_ff;
      if (cmd.load && (dir <= wsm_pkg::DIR_TURN_RIGHT) && (dir != latched_dir_ff)) begin
         latched_dir_in = dir;
         for (int i = 0; i < wsm_pkg::NUM_AXES; i++) begin
            target_in[i] = '0;
         end
         case (dir)
            wsm_pkg::DIR_FORWARD:    target_in[wsm_pkg::AXIS_X]    = spd;
            wsm_pkg::DIR_BACK:       target_in[wsm_pkg::AXIS_X]    = spd_neg;
            wsm_pkg::DIR_LEFT:       target_in[wsm_pkg::AXIS_Y]    = spd;
            wsm_pkg::DIR_RIGHT:      target_in[wsm_pkg::AXIS_Y]    = spd_neg;
            wsm_pkg::DIR_TURN_LEFT:  target_in[wsm_pkg::AXIS_TURN] = spd;
            wsm_pkg::DIR_TURN_RIGHT: target_in[wsm_pkg::AXIS_TURN] = spd_neg;
            default: ;
         endcase
      end
   end

   assign target_sel = target_ff[cmd.idx];
   assign filt_sel   = filt_ff[cmd.idx];
   assign wheel_sel  = wheel_ff[cmd.idx];
   assign gain_comp  = {1'b1, {wsm_pkg::GAIN_W{1'b0}}} - {1'b0, cfg.smoothing_gain};
   assign wheel_gain = ((cmd.idx == wsm_pkg::WHEEL_LF) || (cmd.idx == wsm_pkg::WHEEL_RF)) ?
                       cfg.front_gain : cfg.back_gain;

   always_comb begin
      case (cmd.mul_sel)
         wsm_pkg::MUL_GT: begin
            mul_a = wsm_pkg::OP_W'(target_sel) <<< wsm_pkg::TARGET_SHIFT;
            mul_b = wsm_pkg::OP_W'(cfg.smoothing_gain);
         end
         wsm_pkg::MUL_GF: begin
            mul_a = wsm_pkg::OP_W'(filt_sel);
            mul_b = wsm_pkg::OP_W'(gain_comp);
         end
         wsm_pkg::MUL_ARM: begin
            mul_a = wsm_pkg::OP_W'(filt_ff[wsm_pkg::AXIS_TURN]);
            mul_b = wsm_pkg::OP_W'(cfg.arm_length);
         end
         wsm_pkg::MUL_GAIN: begin
            mul_a = wheel_sel[wsm_pkg::OP_W-1:0];
            mul_b = wsm_pkg::OP_W'(wheel_gain);
         end
         wsm_pkg::MUL_OUT: begin
            mul_a = prod_ff[wsm_pkg::GAIN_SHIFT +: wsm_pkg::OP_W];
            mul_b = wsm_pkg::OP_W'(cfg.output_gain);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // wheel order: left front, left back, right back, right front
   assign x_neg        = (cmd.idx == wsm_pkg::WHEEL_RB) || (cmd.idx == wsm_pkg::WHEEL_RF);
   assign y_neg        = (cmd.idx == wsm_pkg::WHEEL_LB) || (cmd.idx == wsm_pkg::WHEEL_RB);
   assign x_term       = x_neg ? -wsm_pkg::WHEEL_W'(filt_ff[wsm_pkg::AXIS_X])
                               :  wsm_pkg::WHEEL_W'(filt_ff[wsm_pkg::AXIS_X]);
   assign y_term       = y_neg ? -wsm_pkg::WHEEL_W'(filt_ff[wsm_pkg::AXIS_Y])
                               :  wsm_pkg::WHEEL_W'(filt_ff[wsm_pkg::AXIS_Y]);
   assign mix_sum      = x_term + y_term + wsm_pkg::WHEEL_W'(turn_ff);
   assign mix_mag_full = mix_sum[wsm_pkg::WHEEL_W-1] ? -mix_sum : mix_sum;
   assign mix_mag      = mix_mag_full[wsm_pkg::MAG_W-1:0];

   assign wheel_sel_mag = wheel_sel[wsm_pkg::WHEEL_W-1] ? -wheel_sel : wheel_sel;
   assign div_mag       = wheel_sel_mag[wsm_pkg::MAG_W-1:0];

   assign filt_sum = acc_ff + prod_ff;
   assign out_full = prod_ff[wsm_pkg::PROD_W-1:wsm_pkg::OUT_SHIFT];

   always_comb begin
      if (out_full > OUT_MAX) begin
         out_sat = OUT_MAX;
      end else if (out_full < OUT_MIN) begin
         out_sat = OUT_MIN;
      end else begin
         out_sat = out_full[wsm_pkg::OUT_W-1:0];
      end
   end

   always_comb begin
      acc_in   = acc_ff;
      filt_in  = filt_ff;
      turn_in  = turn_ff;
      wheel_in = wheel_ff;
      mx_in    = mx_ff;
      res_in   = res_ff;
      case (cmd.wr_sel)
         wsm_pkg::WR_ACC:  acc_in = prod_ff;
         wsm_pkg::WR_FILT: filt_in[cmd.idx] = filt_sum[wsm_pkg::FILT_SHIFT +: wsm_pkg::FILT_W];
         wsm_pkg::WR_TURN: begin
            turn_in = prod_ff[wsm_pkg::ARM_SHIFT +: wsm_pkg::TURN_W];
            mx_in   = '0;
         end
         wsm_pkg::WR_MIX: begin
            wheel_in[cmd.idx] = mix_sum;
            if (mix_mag > mx_ff) begin
               mx_in = mix_mag;
            end
         end
         wsm_pkg::WR_DIV:  wheel_in[cmd.idx] = wsm_pkg::WHEEL_W'(div_quot);
         wsm_pkg::WR_RES:  res_in[cmd.idx] = out_sat;
         default: ;
      endcase
   end

   assign rsp_tdata_in = cmd.rsp_load ?
      {res_ff[wsm_pkg::WHEEL_RF], res_ff[wsm_pkg::WHEEL_RB],
       res_ff[wsm_pkg::WHEEL_LB], res_ff[wsm_pkg::WHEEL_LF]} : rsp_tdata_ff;

   wsm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .neg     (wheel_sel[wsm_pkg::WHEEL_W-1]),
      .mag     (div_mag),
      .divisor (mx_ff),
      .done    (div_done),
      .quot    (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         latched_dir_ff <= wsm_pkg::DIR_STOP;
         for (int i = 0; i < wsm_pkg::NUM_AXES; i++) begin
            target_ff[i] <= '0;
            filt_ff[i]   <= '0;
         end
      end else begin
         latched_dir_ff <= latched_dir_in;
         target_ff      <= target_in;
         filt_ff        <= filt_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      turn_ff      <= turn_in;
      wheel_ff     <= wheel_in;
      mx_ff        <= mx_in;
      res_ff       <= res_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign sts.norm_needed = mx_ff > wsm_pkg::NORM_ONE;
   assign sts.div_done    = div_done;
   assign rsp_tdata       = rsp_tdata_ff;

endmodule

[rtl/wsm_ctrl.sv]
// ----------------------------------------------------------------------------
// wsm_ctrl
// Sequencer: steps one item through filter, turn term, mixing, optional
// normalization and gain stage, then hands the result to the output register.
// ----------------------------------------------------------------------------
module wsm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  wsm_pkg::sts_type  sts,
   output wsm_pkg::cmd_type  cmd
);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_FILT = 7'b0000010,
      ST_TURN = 7'b0000100,
      ST_MIX  = 7'b0001000,
      ST_DIV  = 7'b0010000,
      ST_GAIN = 7'b0100000,
      ST_DONE = 7'b1000000
   } state_type;

   localparam logic [1:0] PHASE_A = 2'd0;
   localparam logic [1:0] PHASE_B = 2'd1;
   localparam logic [1:0] PHASE_C = 2'd2;

   localparam logic [wsm_pkg::IDX_W-1:0] LAST_AXIS  = wsm_pkg::IDX_W'(wsm_pkg::NUM_AXES - 1);
   localparam logic [wsm_pkg::IDX_W-1:0] LAST_WHEEL = wsm_pkg::IDX_W'(wsm_pkg::NUM_WHEELS - 1);

   state_type                   state_ff, state_in;
   logic [wsm_pkg::IDX_W-1:0]   idx_ff, idx_in;
   logic [1:0]                  phase_ff, phase_in;
   logic                        rsp_tvalid_ff, rsp_tvalid_in;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      phase_in      = phase_ff;
      cmd.load      = 1'b0;
      cmd.mul_sel   = wsm_pkg::MUL_NONE;
      cmd.wr_sel    = wsm_pkg::WR_NONE;
      cmd.idx       = idx_ff;
      cmd.div_start = 1'b0;
      cmd.rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_FILT;
               idx_in   = '0;
               phase_in = PHASE_A;
            end
         end
         ST_FILT: begin
            case (phase_ff)
               PHASE_A: begin
                  cmd.mul_sel = wsm_pkg::MUL_GT;
                  phase_in    = PHASE_B;
               end
               PHASE_B: begin
                  cmd.wr_sel  = wsm_pkg::WR_ACC;
                  cmd.mul_sel = wsm_pkg::MUL_GF;
                  phase_in    = PHASE_C;
               end
               default: begin
                  cmd.wr_sel = wsm_pkg::WR_FILT;
                  phase_in   = PHASE_A;
                  if (idx_ff == LAST_AXIS) begin
                     state_in = ST_TURN;
                     idx_in   = '0;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
            endcase
         end
         ST_TURN: begin
            case (phase_ff)
               PHASE_A: begin
                  cmd.mul_sel = wsm_pkg::MUL_ARM;
                  phase_in    = PHASE_B;
               end
               default: begin
                  cmd.wr_sel = wsm_pkg::WR_TURN;
                  phase_in   = PHASE_A;
                  idx_in     = '0;
                  state_in   = ST_MIX;
               end
            endcase
         end
         ST_MIX: begin
            cmd.wr_sel = wsm_pkg::WR_MIX;
            if (idx_ff == LAST_WHEEL) begin
               state_in = ST_DIV;
               idx_in   = '0;
               phase_in = PHASE_A;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DIV: begin
            case (phase_ff)
               PHASE_A: begin
                  if (!sts.norm_needed) begin
                     state_in = ST_GAIN;
                     idx_in   = '0;
                  end else begin
                     cmd.div_start = 1'b1;
                     phase_in      = PHASE_B;
                  end
               end
               default: begin
                  if (sts.div_done) begin
                     cmd.wr_sel = wsm_pkg::WR_DIV;
                     phase_in   = PHASE_A;
                     if (idx_ff == LAST_WHEEL) begin
                        state_in = ST_GAIN;
                        idx_in   = '0;
                     end else begin
                        idx_in = idx_ff + 1'b1;
                     end
                  end
               end
            endcase
         end
         ST_GAIN: begin
            case (phase_ff)
               PHASE_A: begin
                  cmd.mul_sel = wsm_pkg::MUL_GAIN;
                  phase_in    = PHASE_B;
               end
               PHASE_B: begin
                  cmd.mul_sel = wsm_pkg::MUL_OUT;
                  phase_in    = PHASE_C;
               end
               default: begin
                  cmd.wr_sel = wsm_pkg::WR_RES;
                  phase_in   = PHASE_A;
                  if (idx_ff == LAST_WHEEL) begin
                     state_in = ST_DONE;
                     idx_in   = '0;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
            endcase
         end
         ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            idx_in   = '0;
            phase_in = PHASE_A;
         end
      endcase
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (cmd.rsp_load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         phase_ff      <= PHASE_A;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         phase_ff      <= phase_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;

endmodule

[rtl/omni_chassis_wheel_speed_mixer.sv]
// ----------------------------------------------------------------------------
// omni_chassis_wheel_speed_mixer
// Four-wheel omni drive inverse kinematics: direction and speed in, four
// smoothed, normalized and scaled wheel rates out.
// ----------------------------------------------------------------------------
// The block works on one item at a time; normalization runs only when some
// wheel sum exceeds unit magnitude. Processing is bounded by the one shared
// 25x25 multiplier (two products per filter axis, one for the turn term, two
// per wheel) and by the one-bit-per-cycle divider, run once per wheel (21
// steps) for normalization. A finished result sits in the output register, so
// the next item is taken while it waits. The user must write registers over
// the csr port only while the block is idle; the block itself does not
// enforce it. The port is always ready.
module omni_chassis_wheel_speed_mixer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [wsm_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [wsm_pkg::CSR_DATA_W-1:0]        csr_data,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [2:0] direction, [18:3] speed, [23:19] zero
   input  logic [wsm_pkg::REQ_DATA_W-1:0]        req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [21:0] left_front_speed, [43:22] left_back_speed,
   // [65:44] right_back_speed, [87:66] right_front_speed
   output logic [wsm_pkg::RSP_DATA_W-1:0]        rsp_tdata
);

   wsm_pkg::cfg_type  cfg_ff, cfg_in;
   wsm_pkg::cmd_type  cmd;
   wsm_pkg::sts_type  sts;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            wsm_pkg::CSR_SMOOTHING_GAIN: cfg_in.smoothing_gain = csr_data[wsm_pkg::GAIN_W-1:0];
            wsm_pkg::CSR_ARM_LENGTH:     cfg_in.arm_length     = csr_data[wsm_pkg::GAIN_W-1:0];
            wsm_pkg::CSR_FRONT_GAIN:     cfg_in.front_gain     = csr_data[wsm_pkg::GAIN_W-1:0];
            wsm_pkg::CSR_BACK_GAIN:      cfg_in.back_gain      = csr_data[wsm_pkg::GAIN_W-1:0];
            wsm_pkg::CSR_OUTPUT_GAIN:    cfg_in.output_gain    = csr_data[wsm_pkg::OGAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= wsm_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;

   wsm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   wsm_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cfg       (cfg_ff),
      .req_tdata (req_tdata),
      .sts       (sts),
      .rsp_tdata (rsp_tdata)
   );

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_tvalid || rsp_tready))
      else $error("result register loaded over an item not yet taken");

   a_div_only_when_norm: assert property (@(posedge clock) disable iff (reset)
      sts.div_done |-> sts.norm_needed)
      else $error("divider finished without a normalization pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input ready right after an item was accepted");

endmodule
